// File: rtl/core/ibfd_pkg.sv
// Shared types and constants for the iBUS frame decoder.
// Used by the controller, the datapath and the top level; no dependencies.
package ibfd_pkg;

  // Default number of channels in a frame
  localparam int unsigned DefChannels = 14;

  // Fixed field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChanIdxW = 4;
  localparam int unsigned ChanValW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHeaderFirst  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeaderSecond = 1'b1;

  // Reset values of the header registers
  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'h20;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h40;

  // Checksum seed
  localparam logic [ChanValW-1:0] SumSeed = 16'hFFFF;

  // Result kinds
  localparam logic KindChannel = 1'b0;
  localparam logic KindError   = 1'b1;

  // Operation on the running checksum
  typedef enum logic [1:0] {
    SumHold,
    SumInit,
    SumInitSub,
    SumSub
  } sum_op_e;

  // Controller to datapath commands
  typedef struct packed {
    sum_op_e               sum_op;
    logic                  lo_load;
    logic                  store_we;
    logic [ChanIdxW-1:0]   store_slot;
    logic                  sumlo_load;
    logic                  out_load;
    logic                  out_err;
    logic [ChanIdxW-1:0]   out_idx;
  } ibfd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hdr1_match;
    logic hdr2_match;
    logic sum_match;
  } ibfd_status_t;

endpackage

// File: rtl/core/ibfd_ctrl.sv
// Frame sequencer of the iBUS frame decoder: phase, byte count and emission.
// Depends on ibfd_pkg for the command and status structs.
module ibfd_ctrl #(
  parameter int unsigned Channels = ibfd_pkg::DefChannels
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  input  ibfd_pkg::ibfd_status_t  status_i,
  output ibfd_pkg::ibfd_cmd_t     cmd_o
);

  localparam int unsigned CntW = $clog2(2 * Channels);
  localparam logic [CntW-1:0] CntLast = CntW'(2 * Channels - 1);
  localparam logic [ibfd_pkg::ChanIdxW-1:0] IdxLast = ibfd_pkg::ChanIdxW'(Channels - 1);

  // Phase codes
  localparam logic [2:0] PhHunt1   = 3'd0;
  localparam logic [2:0] PhHunt2   = 3'd1;
  localparam logic [2:0] PhPayload = 3'd2;
  localparam logic [2:0] PhSumLo   = 3'd3;
  localparam logic [2:0] PhSumHi   = 3'd4;

  logic [2:0]                     phase_q, phase_d;
  logic [CntW-1:0]                count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  logic                           err_q, err_d;
  logic [ibfd_pkg::ChanIdxW-1:0]  idx_q, idx_d;
  logic                           in_acc, out_acc, emit_last;

  // Input is held off while a frame's results go out
  assign in_stall_o  = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i & ~out_valid_q;
  assign out_acc     = out_valid_q & ~out_stall_i;
  assign emit_last   = err_q | (idx_q == IdxLast);

  // Next state and commands
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    err_d       = err_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    cmd_o.sum_op     = ibfd_pkg::SumHold;
    cmd_o.store_slot = ibfd_pkg::ChanIdxW'(count_q >> 1);
    cmd_o.out_idx    = idx_q;
    cmd_o.out_err    = err_q;

    if (in_acc) begin
      unique case (phase_q)
        PhHunt2: begin
          if (status_i.hdr2_match) begin
            cmd_o.sum_op = ibfd_pkg::SumSub;
            count_d      = '0;
            phase_d      = PhPayload;
          end else begin
            // retry this byte as a first header byte
            count_d = '0;
            if (status_i.hdr1_match) begin
              cmd_o.sum_op = ibfd_pkg::SumInitSub;
              phase_d      = PhHunt2;
            end else begin
              cmd_o.sum_op = ibfd_pkg::SumInit;
              phase_d      = PhHunt1;
            end
          end
        end
        PhPayload: begin
          cmd_o.sum_op = ibfd_pkg::SumSub;
          if (!count_q[0]) begin
            cmd_o.lo_load = 1'b1;
          end else begin
            cmd_o.store_we = 1'b1;
          end
          count_d = count_q + CntW'(1);
          if (count_q == CntLast) begin
            phase_d = PhSumLo;
          end
        end
        PhSumLo: begin
          cmd_o.sumlo_load = 1'b1;
          phase_d          = PhSumHi;
        end
        PhSumHi: begin
          cmd_o.sum_op   = ibfd_pkg::SumInit;
          count_d        = '0;
          phase_d        = PhHunt1;
          // launch the first result of the frame
          cmd_o.out_load = 1'b1;
          cmd_o.out_err  = ~status_i.sum_match;
          cmd_o.out_idx  = '0;
          err_d          = ~status_i.sum_match;
          idx_d          = '0;
          out_valid_d    = 1'b1;
        end
        default: begin
          // first header hunt, also for unused codes
          count_d = '0;
          if (status_i.hdr1_match) begin
            cmd_o.sum_op = ibfd_pkg::SumInitSub;
            phase_d      = PhHunt2;
          end else begin
            cmd_o.sum_op = ibfd_pkg::SumInit;
            phase_d      = PhHunt1;
          end
        end
      endcase
    end else if (out_acc) begin
      // step through the stored channels
      if (emit_last) begin
        out_valid_d = 1'b0;
      end else begin
        idx_d          = idx_q + ibfd_pkg::ChanIdxW'(1);
        cmd_o.out_load = 1'b1;
        cmd_o.out_idx  = idx_q + ibfd_pkg::ChanIdxW'(1);
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt1;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      err_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
      idx_q       <= idx_d;
    end
  end

endmodule

// File: rtl/core/ibfd_dp.sv
// Datapath of the iBUS frame decoder: header registers, checksum, channel
// store and result registers. Depends on ibfd_pkg.
module ibfd_dp #(
  parameter int unsigned Channels = ibfd_pkg::DefChannels
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ibfd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ibfd_pkg::ByteW-1:0]          cfg_data_i,
  input  logic [ibfd_pkg::ByteW-1:0]          rx_byte_i,
  input  ibfd_pkg::ibfd_cmd_t                 cmd_i,
  output ibfd_pkg::ibfd_status_t              status_o,
  output logic                                kind_o,
  output logic [ibfd_pkg::ChanIdxW-1:0]       channel_index_o,
  output logic [ibfd_pkg::ChanValW-1:0]       channel_value_o,
  output logic                                last_o
);

  localparam int unsigned SlotW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [ibfd_pkg::ChanIdxW-1:0] IdxLast = ibfd_pkg::ChanIdxW'(Channels - 1);

  logic [ibfd_pkg::ByteW-1:0]     hdr1_q, hdr2_q;
  logic [ibfd_pkg::ChanValW-1:0]  sum_q, sum_d;
  logic [ibfd_pkg::ByteW-1:0]     sum_lo_q;
  logic [ibfd_pkg::ByteW-1:0]     lo_hold_q;
  logic [ibfd_pkg::ChanValW-1:0]  store_q [Channels];
  logic [ibfd_pkg::ChanValW-1:0]  rx_ext, got_sum;

  logic                           kind_q, last_q;
  logic [ibfd_pkg::ChanIdxW-1:0]  idx_q;
  logic [ibfd_pkg::ChanValW-1:0]  value_q;

  assign rx_ext  = {{(ibfd_pkg::ChanValW - ibfd_pkg::ByteW){1'b0}}, rx_byte_i};
  assign got_sum = {rx_byte_i, sum_lo_q};

  // Compare results for the sequencer
  assign status_o.hdr1_match = (rx_byte_i == hdr1_q);
  assign status_o.hdr2_match = (rx_byte_i == hdr2_q);
  assign status_o.sum_match  = (got_sum == sum_q);

  // Header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q <= ibfd_pkg::HeaderFirstRst;
      hdr2_q <= ibfd_pkg::HeaderSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ibfd_pkg::CfgHeaderFirst:  hdr1_q <= cfg_data_i;
        ibfd_pkg::CfgHeaderSecond: hdr2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Running checksum
  always_comb begin
    unique case (cmd_i.sum_op)
      ibfd_pkg::SumInit:    sum_d = ibfd_pkg::SumSeed;
      ibfd_pkg::SumInitSub: sum_d = ibfd_pkg::SumSeed - rx_ext;
      ibfd_pkg::SumSub:     sum_d = sum_q - rx_ext;
      default:              sum_d = sum_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= ibfd_pkg::SumSeed;
      sum_lo_q  <= '0;
      lo_hold_q <= '0;
    end else begin
      sum_q <= sum_d;
      if (cmd_i.sumlo_load) begin
        sum_lo_q <= rx_byte_i;
      end
      if (cmd_i.lo_load) begin
        lo_hold_q <= rx_byte_i;
      end
    end
  end

  // Channel store, written once per completed channel
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_q[cmd_i.store_slot[SlotW-1:0]] <= {rx_byte_i, lo_hold_q};
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      kind_q <= cmd_i.out_err ? ibfd_pkg::KindError : ibfd_pkg::KindChannel;
      idx_q  <= cmd_i.out_err ? '0 : cmd_i.out_idx;
      value_q <= cmd_i.out_err ? '0 : store_q[cmd_i.out_idx[SlotW-1:0]];
      last_q <= cmd_i.out_err | (cmd_i.out_idx == IdxLast);
    end
  end

  assign kind_o          = kind_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = value_q;
  assign last_o          = last_q;

endmodule

// File: rtl/core/ibus_frame_decoder.sv
// iBUS frame decoder. One received byte is taken per clock while no results
// are pending. A frame is two header bytes, 2*Channels payload bytes and a
// little-endian checksum; after the checksum high byte the block emits
// Channels channel results (or one error result on a checksum mismatch),
// one per clock as the output side takes them, and holds in_stall_o high
// until the last one is taken. Results go out through the single result
// register, which steps through the channel store.
// Depends on ibfd_pkg, ibfd_ctrl and ibfd_dp.
module ibus_frame_decoder #(
  parameter int unsigned Channels = ibfd_pkg::DefChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ibfd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ibfd_pkg::ByteW-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ibfd_pkg::ByteW-1:0]     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic [ibfd_pkg::ChanIdxW-1:0]  channel_index_o,
  output logic [ibfd_pkg::ChanValW-1:0]  channel_value_o,
  output logic                           last_o
);

  ibfd_pkg::ibfd_cmd_t    cmd;
  ibfd_pkg::ibfd_status_t status;

  // Sequencer
  ibfd_ctrl #(
    .Channels (Channels)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Datapath
  ibfd_dp #(
    .Channels (Channels)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .kind_o          (kind_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_o          (last_o)
  );

endmodule
